FILE: hdl/wto_pkg.sv
// ============================================================================
// wto_pkg
// Shared widths, codes and defaults for the wavetable oscillator.
// ============================================================================
package wto_pkg;

    // Parameter defaults
    localparam int DEF_TABLE_SIZE  = 2048;
    localparam int DEF_MAX_TABLES  = 8;
    localparam int DEF_SAMPLE_BITS = 16;

    // Fixed field widths
    localparam int ACTION_W    = 2;
    localparam int FRAME_FLD_W = 3;
    localparam int INDEX_FLD_W = 11;
    localparam int VALUE_W     = 16;
    localparam int SAMPLE_W    = 16;
    localparam int PHASE_W     = 32;
    localparam int FRAC_W      = 16;
    localparam int COUNT_W     = 4;
    localparam int SELECT_W    = 3;
    localparam int CMP_W       = 5;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;

    localparam logic [COUNT_W-1:0] COUNT_RESET = 4'd4;

    // Action codes
    localparam logic [ACTION_W-1:0] ACT_TICK  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_WRITE = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_READ  = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd3;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_PHASE_STEP   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TABLE_COUNT  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_TABLE_SELECT = 2'd2;

endpackage

FILE: hdl/wto_item_if.sv
// ============================================================================
// wto_item_if
// Input transaction channel: action, frame, index and sample value.
// ============================================================================
interface wto_item_if
    import wto_pkg::*;
();
    logic                        valid;
    logic                        ready;
    logic [ACTION_W-1:0]         action;
    logic [FRAME_FLD_W-1:0]      frame;
    logic [INDEX_FLD_W-1:0]      index;
    logic signed [VALUE_W-1:0]   value;

    modport source (output valid, output action, output frame, output index,
                    output value, input ready);
    modport sink   (input valid, input action, input frame, input index,
                    input value, output ready);
endinterface

FILE: hdl/wto_result_if.sv
// ============================================================================
// wto_result_if
// Result transaction channel: sample and read-answer flag.
// ============================================================================
interface wto_result_if
    import wto_pkg::*;
();
    logic                        valid;
    logic                        ready;
    logic signed [SAMPLE_W-1:0]  sample;
    logic                        from_read;

    modport source (output valid, output sample, output from_read, input ready);
    modport sink   (input valid, input sample, input from_read, output ready);
endinterface

FILE: hdl/wavetable_oscillator.sv
// ============================================================================
// wavetable_oscillator
// Multi-frame wavetable oscillator with linear interpolation and host access
// to single samples.
// ============================================================================
//
//  channel   | role | carries
//  ----------+------+---------------------------------------------------------
//  item      | sink | action, frame, index, value (tick/write/read/clear)
//  result    | src  | sample, from_read (tick output or read answer)
//  cfg_*     | in   | write-only registers: phase_step, table_count, select
//
//  Rate: one transaction per cycle sustained while result.ready holds. A
//  result passes the bank read register, the product register and the
//  output register in turn after the edge that accepts its item.
//  The store is split into even and odd index banks so that both neighbors
//  of a tick are read in the same cycle.
//  Reset clears phase, step, select and pipeline valids and sets the table
//  count to four; the store is not cleared and holds undefined data until written.
//  A stall on result reaches item.ready in the same cycle through the
//  combinational ready chain; item.ready drops only when every stage holds
//  a result.
//  TABLE_SIZE must be a power of two.
//
module wavetable_oscillator
    import wto_pkg::*;
#(
    parameter int TABLE_SIZE  = DEF_TABLE_SIZE,
    parameter int MAX_TABLES  = DEF_MAX_TABLES,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  logic                   clk,
    input  logic                   rst_n,
    wto_item_if.sink               item,
    wto_result_if.source           result,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int IDX_W   = $clog2(TABLE_SIZE);
    localparam int HALF_W  = IDX_W - 1;
    localparam int FRAME_W = (MAX_TABLES > 1) ? $clog2(MAX_TABLES) : 1;
    localparam int ADDR_W  = FRAME_W + HALF_W;
    localparam int BANK_DEPTH = MAX_TABLES * (TABLE_SIZE / 2);
    localparam int SB      = SAMPLE_BITS;
    localparam int PROD_W  = SB + FRAC_W + 2;
    localparam int ACC_W   = 48;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [PHASE_W-1:0]  phase_step_reg;
    logic [COUNT_W-1:0]  table_count_reg;
    logic [SELECT_W-1:0] table_select_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_step_reg   <= '0;
            table_count_reg  <= COUNT_RESET;
            table_select_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_PHASE_STEP:   phase_step_reg   <= cfg_data[PHASE_W-1:0];
                REG_TABLE_COUNT:  table_count_reg  <= cfg_data[COUNT_W-1:0];
                REG_TABLE_SELECT: table_select_reg <= cfg_data[SELECT_W-1:0];
                default:          ;
            endcase
        end
    end

    // Frames in use: zero acts as one, saturate at the store size
    logic [CMP_W-1:0] count_used;
    logic [CMP_W-1:0] select_used;

    always_comb
    begin
        if (table_count_reg == '0)
        begin
            count_used = CMP_W'(1);
        end
        else if (CMP_W'(table_count_reg) > CMP_W'(MAX_TABLES))
        begin
            count_used = CMP_W'(MAX_TABLES);
        end
        else
        begin
            count_used = CMP_W'(table_count_reg);
        end

        if (CMP_W'(table_select_reg) >= count_used)
        begin
            select_used = count_used - CMP_W'(1);
        end
        else
        begin
            select_used = CMP_W'(table_select_reg);
        end
    end

    // ------------------------------------------------------------------
    // Pipeline handshake: each stage moves when the next has room
    // ------------------------------------------------------------------
    logic s1_valid_reg, s2_valid_reg, out_valid_reg;
    logic out_ready, s2_ready, s1_ready;
    logic item_accept;

    assign out_ready   = !out_valid_reg || result.ready;
    assign s2_ready    = !s2_valid_reg || out_ready;
    assign s1_ready    = !s1_valid_reg || s2_ready;
    assign item.ready  = s1_ready;
    assign item_accept = item.valid && s1_ready;

    // ------------------------------------------------------------------
    // Stage 0: decode, phase accumulator, bank addressing
    // ------------------------------------------------------------------
    logic [PHASE_W-1:0] phase_acc_reg;
    logic               is_tick, is_write, is_read, is_clear;
    logic               in_range;
    logic [IDX_W-1:0]   item_idx;
    logic [IDX_W-1:0]   base_idx;
    logic [FRAME_W-1:0] base_frame;
    logic [HALF_W-1:0]  odd_half, even_half;
    logic [FRAC_W-1:0]  phase_frac;

    always_comb
    begin
        is_tick  = 1'b0;
        is_write = 1'b0;
        is_read  = 1'b0;
        is_clear = 1'b0;
        unique case (item.action)
            ACT_TICK:  is_tick  = 1'b1;
            ACT_WRITE: is_write = 1'b1;
            ACT_READ:  is_read  = 1'b1;
            ACT_CLEAR: is_clear = 1'b1;
            default:   ;
        endcase
    end

    assign item_idx   = IDX_W'(item.index);
    assign in_range   = (CMP_W'(item.frame) < count_used)
                     && (32'(item.index) < 32'(TABLE_SIZE));
    assign phase_frac = phase_acc_reg[PHASE_W-IDX_W-1 -: FRAC_W];

    // A tick reads index i0 and i0+1; the odd bank always serves half i0/2,
    // the even bank half i0/2 + i0[0], wrapping inside the frame.
    assign base_idx   = is_tick ? phase_acc_reg[PHASE_W-1 -: IDX_W] : item_idx;
    assign base_frame = is_tick ? FRAME_W'(select_used) : FRAME_W'(item.frame);
    assign odd_half   = base_idx[IDX_W-1:1];
    assign even_half  = odd_half + HALF_W'(base_idx[0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_acc_reg <= '0;
        end
        else if (item_accept && is_tick)
        begin
            phase_acc_reg <= phase_acc_reg + phase_step_reg;
        end
        else if (item_accept && is_clear)
        begin
            phase_acc_reg <= '0;
        end
    end

    // ------------------------------------------------------------------
    // Sample banks: writes and reads issue in item order at stage 0,
    // so a read right after a write to the same entry sees the new data.
    // ------------------------------------------------------------------
    logic              wr_even, wr_odd;
    logic [ADDR_W-1:0] wr_addr;
    logic [SB-1:0]     wr_data;
    logic [SB-1:0]     even_q, odd_q;

    assign wr_addr = {FRAME_W'(item.frame), item_idx[IDX_W-1:1]};
    assign wr_data = SB'($unsigned(item.value));
    assign wr_even = item_accept && is_write && in_range && !item_idx[0];
    assign wr_odd  = item_accept && is_write && in_range && item_idx[0];

    wto_bank_ram #(
        .DEPTH  (BANK_DEPTH),
        .ADDR_W (ADDR_W),
        .DATA_W (SB)
    ) u_even_bank (
        .clk     (clk),
        .wr_en   (wr_even),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (s1_ready),
        .rd_addr ({base_frame, even_half}),
        .rd_data (even_q)
    );

    wto_bank_ram #(
        .DEPTH  (BANK_DEPTH),
        .ADDR_W (ADDR_W),
        .DATA_W (SB)
    ) u_odd_bank (
        .clk     (clk),
        .wr_en   (wr_odd),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (s1_ready),
        .rd_addr ({base_frame, odd_half}),
        .rd_data (odd_q)
    );

    // ------------------------------------------------------------------
    // Stage 1: bank data present; form s1 - s0 and the fraction product
    // ------------------------------------------------------------------
    logic              s1_read_reg, s1_oor_reg, s1_odd_reg;
    logic [FRAC_W-1:0] s1_frac_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_ready)
        begin
            s1_valid_reg <= item_accept && (is_tick || is_read);
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready)
        begin
            s1_read_reg <= is_read;
            s1_oor_reg  <= !in_range;
            s1_odd_reg  <= base_idx[0];
            s1_frac_reg <= phase_frac;
        end
    end

    logic [SB-1:0]            samp0, samp1;
    logic signed [SB:0]       diff;
    logic signed [PROD_W-1:0] prod;

    assign samp0 = s1_odd_reg ? odd_q : even_q;
    assign samp1 = s1_odd_reg ? even_q : odd_q;
    assign diff  = $signed({samp1[SB-1], samp1}) - $signed({samp0[SB-1], samp0});
    assign prod  = PROD_W'($signed({1'b0, s1_frac_reg})) * PROD_W'(diff);

    // ------------------------------------------------------------------
    // Stage 2: add the base sample, truncate toward minus infinity
    // ------------------------------------------------------------------
    logic                     s2_read_reg, s2_oor_reg;
    logic [SB-1:0]            s2_base_reg;
    logic signed [PROD_W-1:0] s2_prod_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_ready)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_ready)
        begin
            s2_read_reg <= s1_read_reg;
            s2_oor_reg  <= s1_oor_reg;
            s2_base_reg <= samp0;
            s2_prod_reg <= prod;
        end
    end

    logic signed [ACC_W-1:0]    base_ext;
    logic signed [ACC_W-1:0]    interp_acc;
    logic signed [SAMPLE_W-1:0] next_sample;

    assign base_ext   = ACC_W'($signed(s2_base_reg));
    assign interp_acc = (base_ext <<< FRAC_W) + ACC_W'(s2_prod_reg);

    always_comb
    begin
        if (!s2_read_reg)
        begin
            next_sample = interp_acc[FRAC_W +: SAMPLE_W];
        end
        else if (s2_oor_reg)
        begin
            next_sample = '0;
        end
        else
        begin
            next_sample = base_ext[SAMPLE_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic signed [SAMPLE_W-1:0] sample_reg;
    logic                       from_read_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_ready)
        begin
            out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_ready)
        begin
            sample_reg    <= next_sample;
            from_read_reg <= s2_read_reg;
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.sample    = sample_reg;
    assign result.from_read = from_read_reg;

`ifndef SYNTHESIS
    a_tick_advances_phase: assert property (@(posedge clk) disable iff (!rst_n)
        item_accept && is_tick |=> phase_acc_reg == $past(phase_acc_reg + phase_step_reg))
        else $error("phase did not advance by phase_step on a tick");

    a_clear_zeroes_phase: assert property (@(posedge clk) disable iff (!rst_n)
        item_accept && is_clear |=> phase_acc_reg == '0)
        else $error("phase not cleared");

    a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        item_accept && is_write && s1_ready |=> !s1_valid_reg)
        else $error("write transaction produced a result");

    // Unused neighbor words may be undefined; compare them bit for bit.
    a_bank_data_held: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s2_ready |=> s1_valid_reg && (even_q === $past(even_q))
            && (odd_q === $past(odd_q)))
        else $error("bank data lost during stall");
`endif

endmodule

FILE: hdl/wto_bank_ram.sv
// ============================================================================
// wto_bank_ram
// One sample bank: one write port, one registered read port.
// ============================================================================
module wto_bank_ram #(
    parameter int DEPTH  = 8192,
    parameter int ADDR_W = 13,
    parameter int DATA_W = 16
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Hold the last word while the read port is idle
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps
// ============================================================================
// testbench
// Self-checking bench for the wavetable oscillator: a queue-fed driver with
// bursty traffic, a stalling result sink and a cycle-free predictor that
// checks every sample and read answer in order.
// ============================================================================
module testbench;
    import wto_pkg::*;

    localparam int FRAME_LEN    = DEF_TABLE_SIZE;
    localparam int FRAME_SLOTS  = DEF_MAX_TABLES;
    localparam int CLK_PERIOD   = 12;
    localparam int RESET_CYCLES = 5;
    // Pipeline is three stages deep; give writes and clears room to retire.
    localparam int DRAIN_CYCLES = 10;
    localparam int RANDOM_OPS   = 600;
    localparam int PHASE_COUNT  = 6;
    localparam int LONG_HOLD    = 200;
    localparam int HOLD_AFTER   = 300;
    localparam int MAX_REPORTS  = 10;
    localparam int RUN_LIMIT_NS = 10_000_000;

    localparam logic [INDEX_FLD_W-1:0] LAST_INDEX = INDEX_FLD_W'(FRAME_LEN - 1);

    // The index port is two bits wide; the top index hits no register.
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 2'd3;

    typedef struct packed {
        logic [ACTION_W-1:0]       action;
        logic [FRAME_FLD_W-1:0]    frame;
        logic [INDEX_FLD_W-1:0]    index;
        logic signed [VALUE_W-1:0] value;
    } osc_cmd_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       from_read;
    } osc_out_t;

    logic                   clk   = 1'b0;
    logic                   rst_n = 1'b1;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    wto_item_if   item_ch ();
    wto_result_if result_ch ();

    wavetable_oscillator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // ------------------------------------------------------------------------
    // Predictor state: sample memory, phase accumulator and register copies.
    // Register copies are updated only while the block is idle, so the
    // predictor and the stimulus generator may both read them.
    // ------------------------------------------------------------------------
    logic signed [SAMPLE_W-1:0] wave_mem [FRAME_SLOTS][FRAME_LEN];
    logic [PHASE_W-1:0]         osc_phase;
    logic [PHASE_W-1:0]         step_reg;
    logic [COUNT_W-1:0]         count_reg;
    logic [SELECT_W-1:0]        select_reg;
    osc_out_t                   expected_samples [$];

    // Stimulus-side shadow: which entries hold data, and where the phase
    // will be once every queued transaction has been accepted.
    bit                 written_map [FRAME_SLOTS][FRAME_LEN];
    logic [PHASE_W-1:0] stim_phase;
    osc_cmd_t           pending_cmds [$];

    int unsigned fail_count;
    int unsigned results_taken;

    // Saturate the frame count into 1..FRAME_SLOTS; zero acts as one.
    function automatic int unsigned frames_in_use(input logic [COUNT_W-1:0] cnt);
        if (cnt == 0)
            return 1;
        if (cnt > FRAME_SLOTS)
            return FRAME_SLOTS;
        return 32'(cnt);
    endfunction

    // Clamp the selected frame to the last frame in use.
    function automatic int unsigned played_frame(input logic [COUNT_W-1:0] cnt,
                                                 input logic [SELECT_W-1:0] sel);
        int unsigned used;
        used = frames_in_use(cnt);
        return (sel >= used) ? used - 1 : 32'(sel);
    endfunction

    // Advance the predictor by one accepted transaction; return 1 when it
    // produces a result.
    function automatic bit model_osc(input osc_cmd_t cmd, output osc_out_t res);
        int unsigned            used;
        int unsigned            sel;
        logic [INDEX_FLD_W-1:0] i0;
        logic [INDEX_FLD_W-1:0] i1;
        logic [FRAC_W-1:0]      frac;
        longint                 s0;
        longint                 s1;
        longint                 acc;
        used = frames_in_use(count_reg);
        res  = '0;
        case (cmd.action)
            ACT_TICK:
            begin
                // Top bits index the entry in the frame, the next ones weight the neighbor,
                // which wraps to entry zero past the end.
                sel  = played_frame(count_reg, select_reg);
                i0   = osc_phase[PHASE_W-1 -: INDEX_FLD_W];
                i1   = i0 + 1'b1;
                frac = osc_phase[PHASE_W-INDEX_FLD_W-1 -: FRAC_W];
                s0   = longint'(wave_mem[sel][i0]);
                s1   = longint'(wave_mem[sel][i1]);
                acc  = s0 * 65536 + longint'(frac) * (s1 - s0);
                // Arithmetic shift floors toward minus infinity.
                res.sample    = SAMPLE_W'(acc >>> FRAC_W);
                res.from_read = 1'b0;
                osc_phase     = osc_phase + step_reg;
                return 1'b1;
            end
            ACT_WRITE:
            begin
                if (cmd.frame < used)
                    wave_mem[cmd.frame][cmd.index] = cmd.value;
                return 1'b0;
            end
            ACT_READ:
            begin
                res.from_read = 1'b1;
                if (cmd.frame < used)
                    res.sample = wave_mem[cmd.frame][cmd.index];
                return 1'b1;
            end
            default:
            begin
                osc_phase = '0;
                return 1'b0;
            end
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers. Every transaction goes through queue_cmd so that the
    // shadow phase and the written-entry map track the block exactly.
    // ------------------------------------------------------------------------
    function automatic osc_cmd_t random_cmd(input logic [ACTION_W-1:0] act);
        osc_cmd_t c;
        c        = osc_cmd_t'($urandom);
        c.action = act;
        return c;
    endfunction

    task automatic queue_cmd(input osc_cmd_t c);
        case (c.action)
            ACT_TICK:  stim_phase = stim_phase + step_reg;
            ACT_CLEAR: stim_phase = '0;
            ACT_WRITE:
            begin
                if (c.frame < frames_in_use(count_reg))
                    written_map[c.frame][c.index] = 1'b1;
            end
            default: ;
        endcase
        pending_cmds.push_back(c);
    endtask

    task automatic queue_write(input int unsigned fr, input logic [INDEX_FLD_W-1:0] idx,
                               input logic signed [VALUE_W-1:0] val);
        osc_cmd_t c;
        c       = random_cmd(ACT_WRITE);
        c.frame = FRAME_FLD_W'(fr);
        c.index = idx;
        c.value = val;
        queue_cmd(c);
    endtask

    // Store random data into an entry before anything reads it.
    task automatic fill_entry(input int unsigned fr, input logic [INDEX_FLD_W-1:0] idx);
        if (!written_map[fr][idx])
            queue_write(fr, idx, VALUE_W'($urandom));
    endtask

    task automatic queue_tick();
        int unsigned            fr;
        logic [INDEX_FLD_W-1:0] idx;
        logic [INDEX_FLD_W-1:0] next_idx;
        fr       = played_frame(count_reg, select_reg);
        idx      = stim_phase[PHASE_W-1 -: INDEX_FLD_W];
        next_idx = idx + 1'b1;
        fill_entry(fr, idx);
        fill_entry(fr, next_idx);
        queue_cmd(random_cmd(ACT_TICK));
    endtask

    task automatic queue_read(input int unsigned fr, input logic [INDEX_FLD_W-1:0] idx);
        osc_cmd_t c;
        if (fr < frames_in_use(count_reg))
            fill_entry(fr, idx);
        c       = random_cmd(ACT_READ);
        c.frame = FRAME_FLD_W'(fr);
        c.index = idx;
        queue_cmd(c);
    endtask

    // Mostly well-formed traffic, with stray writes, clears and tick runs.
    task automatic queue_random_op();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 45)
            queue_tick();
        else if (pick < 65)
            queue_cmd(random_cmd(ACT_WRITE));
        else if (pick < 85)
            queue_read($urandom_range(0, FRAME_SLOTS - 1), INDEX_FLD_W'($urandom));
        else if (pick < 90)
            queue_cmd(random_cmd(ACT_CLEAR));
        else
            repeat ($urandom_range(3, 12)) queue_tick();
    endtask

    // Write one register; unused data bits carry noise.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            REG_PHASE_STEP:   step_reg   = data;
            REG_TABLE_COUNT:  count_reg  = data[COUNT_W-1:0];
            REG_TABLE_SELECT: select_reg = data[SELECT_W-1:0];
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_config(input logic [PHASE_W-1:0] step,
                              input logic [COUNT_W-1:0] cnt,
                              input logic [SELECT_W-1:0] sel);
        logic [CFG_DATA_W-1:0] data;
        write_reg(REG_PHASE_STEP, step);
        data                = $urandom;
        data[COUNT_W-1:0]   = cnt;
        write_reg(REG_TABLE_COUNT, data);
        data                = $urandom;
        data[SELECT_W-1:0]  = sel;
        write_reg(REG_TABLE_SELECT, data);
    endtask

    // Hold until every queued transaction is accepted and answered, then let
    // writes and clears still in the pipeline retire. Poll on the falling
    // edge so that the driver's updates have settled.
    task automatic wait_idle();
        while (pending_cmds.size() != 0 || item_ch.valid || expected_samples.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic note_failure(input bit had_expect, input osc_out_t want,
                                input osc_out_t got);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
        begin
            if (had_expect)
                $display("mismatch at %0t: expected %0d/%0b, got %0d/%0b",
                         $realtime, $signed(want.sample), want.from_read,
                         $signed(got.sample), got.from_read);
            else
                $display("unexpected result at %0t: sample %0d from_read %0b",
                         $realtime, $signed(got.sample), got.from_read);
        end
    endtask

    // ------------------------------------------------------------------------
    // Driver: offer queued transactions in bursts of random length separated
    // by random gaps. A zero gap chains bursts into long unbroken stretches.
    // ------------------------------------------------------------------------
    int unsigned burst_left;
    int unsigned gap_left;
    osc_cmd_t    next_cmd;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_ch.valid  <= 1'b0;
            item_ch.action <= ACT_TICK;
            item_ch.frame  <= '0;
            item_ch.index  <= '0;
            item_ch.value  <= '0;
            burst_left = 0;
            gap_left   = 0;
        end
        else if (!item_ch.valid || item_ch.ready)
        begin
            if (gap_left != 0)
            begin
                gap_left--;
                item_ch.valid <= 1'b0;
            end
            else if (pending_cmds.size() != 0)
            begin
                next_cmd = pending_cmds.pop_front();
                item_ch.valid  <= 1'b1;
                item_ch.action <= next_cmd.action;
                item_ch.frame  <= next_cmd.frame;
                item_ch.index  <= next_cmd.index;
                item_ch.value  <= next_cmd.value;
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
                else
                    burst_left--;
            end
            else
                item_ch.valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // Result sink: switch between always-ready, coin-flip and sparse-ready
    // stretches. Once, after enough results, hold off for a long stretch so
    // that the pipeline fills and backpressure reaches the item side.
    // ------------------------------------------------------------------------
    int unsigned stall_left;
    int unsigned stall_mode;
    int unsigned hold_left;
    bit          hold_done;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
            stall_left = 0;
            stall_mode = 0;
            hold_left  = 0;
            hold_done  = 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left--;
            result_ch.ready <= 1'b0;
        end
        else if (!hold_done && results_taken >= HOLD_AFTER)
        begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD;
            result_ch.ready <= 1'b0;
        end
        else
        begin
            if (stall_left == 0)
            begin
                stall_mode = $urandom_range(0, 2);
                stall_left = $urandom_range(8, 64);
            end
            else
                stall_left--;
            case (stall_mode)
                0:       result_ch.ready <= 1'b1;
                1:       result_ch.ready <= $urandom_range(0, 1);
                default: result_ch.ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: check each result transaction against the oldest expectation,
    // then run the predictor on each accepted item transaction. Results lag
    // their items by the pipeline, so checking first is safe.
    // ------------------------------------------------------------------------
    osc_cmd_t seen_cmd;
    osc_out_t seen_out;
    osc_out_t due_out;
    osc_out_t model_out;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                results_taken++;
                seen_out.sample    = result_ch.sample;
                seen_out.from_read = result_ch.from_read;
                if (expected_samples.size() == 0)
                    note_failure(1'b0, '0, seen_out);
                else
                begin
                    due_out = expected_samples.pop_front();
                    if (seen_out.sample !== due_out.sample ||
                        seen_out.from_read !== due_out.from_read)
                        note_failure(1'b1, due_out, seen_out);
                end
            end
            if (item_ch.valid && item_ch.ready)
            begin
                seen_cmd.action = item_ch.action;
                seen_cmd.frame  = item_ch.frame;
                seen_cmd.index  = item_ch.index;
                seen_cmd.value  = item_ch.value;
                if (model_osc(seen_cmd, model_out))
                    expected_samples.push_back(model_out);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sequence: reset, directed checks at the reset settings, directed checks
    // at the register extremes, then random phases under varied settings.
    // ------------------------------------------------------------------------
    initial
    begin
        cfg_we    <= 1'b0;
        cfg_index <= REG_PHASE_STEP;
        cfg_data  <= '0;
        // Drop reset at time zero so every driven input resets at once.
        rst_n     <= 1'b0;
        osc_phase     = '0;
        step_reg      = '0;
        count_reg     = COUNT_RESET;
        select_reg    = '0;
        stim_phase    = '0;
        fail_count    = 0;
        results_taken = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: step zero, four frames, frame zero played.
        // Store full-scale values at both ends of a frame and of the range.
        queue_write(0, '0, 16'sh7FFF);
        queue_write(0, INDEX_FLD_W'(1), 16'sh8000);
        queue_write(0, LAST_INDEX, 16'sh8000);
        queue_write(3, LAST_INDEX, 16'sh7FFF);
        // Drop writes to frames past the count in use.
        queue_write(4, INDEX_FLD_W'(5), 16'sh0123);
        queue_write(FRAME_SLOTS - 1, LAST_INDEX, 16'shFFFF);
        queue_read(0, '0);
        queue_read(0, INDEX_FLD_W'(1));
        queue_read(3, LAST_INDEX);
        // Out-of-range reads answer zero.
        queue_read(4, INDEX_FLD_W'(5));
        queue_read(FRAME_SLOTS - 1, LAST_INDEX);
        queue_tick();
        queue_tick();
        queue_cmd(random_cmd(ACT_CLEAR));
        queue_tick();

        // Largest step, zero count (acts as one frame), select beyond range.
        wait_idle();
        set_config('1, '0, '1);
        write_reg(REG_SPARE, $urandom);
        queue_tick();
        // Phase at the top of the cycle interpolates toward entry zero.
        queue_tick();
        queue_tick();
        queue_write(1, '0, 16'sh4000);
        queue_read(1, '0);
        queue_cmd(random_cmd(ACT_CLEAR));
        queue_tick();
        queue_read(0, LAST_INDEX);

        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            wait_idle();
            case (p)
                0:       set_config($urandom_range(1, 32'h0040_0000), 4'd8,
                                    SELECT_W'($urandom_range(0, 7)));
                1:       set_config(32'h8000_0000, 4'd15, 3'd7);
                2:       set_config($urandom, COUNT_W'($urandom_range(0, 15)),
                                    SELECT_W'($urandom_range(0, 7)));
                3:       set_config('0, COUNT_W'($urandom_range(1, 8)), 3'd0);
                4:       set_config($urandom_range(1, 32'h0001_0000), COUNT_RESET, 3'd3);
                default: set_config($urandom, COUNT_W'($urandom_range(0, 15)),
                                    SELECT_W'($urandom_range(0, 7)));
            endcase
            repeat (RANDOM_OPS / PHASE_COUNT) queue_random_op();
        end

        wait_idle();
        if (fail_count == 0 && expected_samples.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Run limit, many times the slowest correct run.
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("simulation failed");
        $finish;
    end

endmodule

FILE: sim.f
hdl/wto_pkg.sv
hdl/wto_item_if.sv
hdl/wto_result_if.sv
hdl/wto_bank_ram.sv
hdl/wavetable_oscillator.sv
tb/sv/testbench.sv
